@@ src/overwrite_ring_buffer_readout_top_assert.svh @@
// Assertion macros shared by the ring buffer readout modules.
`ifndef OVERWRITE_RING_BUFFER_READOUT_TOP_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_READOUT_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ORB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/orb_pkg.sv @@
// Types, constants and command structs for the ring buffer readout block.
package orb_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int REQ_W   = 7;
    localparam int PRES_W  = 16;
    localparam int VALVE_W = 7;
    localparam int TIME_W  = 32;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic push;
        logic clear;
        logic load_read;
        logic read_step;
        logic emit_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic req_zero;
        logic last_step;
    } dp_status_t;

    typedef struct packed {
        logic [PRES_W-1:0]  pressure;
        logic [VALVE_W-1:0] valve;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

endpackage

@@ src/overwrite_ring_buffer_readout_top.sv @@
// Top level of the overwrite-oldest ring buffer with in-order readout.
//
// A word is taken when start is high and busy is low. A push or a clear
// returns nothing; the next word can follow at once. A readout of
// n = min(fill count, max_entries) entries keeps busy high until its final
// read step. It puts one result per cycle on the result ports, oldest first,
// each marked by strobe for exactly one cycle, the final one with last set.
// The entry memory has a registered read, so each result is registered from
// its read step and the final one comes in the first cycle in which busy is
// low again. The rate of one entry per cycle is set by the single read port
// of the entry memory. An empty buffer or a request for zero entries gives
// one result, in the cycle after the word, with entry_valid low and last
// high, and busy stays low. Results cannot be held off: the receiver must
// take each one in its strobe cycle.
// The entry memory needs no clearing after reset.
module overwrite_ring_buffer_readout_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [orb_pkg::PRES_W-1:0]  pressure,
    input  logic [orb_pkg::VALVE_W-1:0] valve_position,
    input  logic [orb_pkg::TIME_W-1:0]  timestamp,
    input  logic [orb_pkg::REQ_W-1:0]   max_entries,
    output logic                        strobe,
    output logic [orb_pkg::PRES_W-1:0]  stored_pressure,
    output logic [orb_pkg::VALVE_W-1:0] stored_valve,
    output logic [orb_pkg::TIME_W-1:0]  stored_time,
    output logic                        entry_valid,
    output logic                        last
);
    import orb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence commands
    orb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Store entries and produce results
    orb_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .pressure        (pressure),
        .valve_position  (valve_position),
        .timestamp       (timestamp),
        .max_entries     (max_entries),
        .status          (status),
        .strobe          (strobe),
        .stored_pressure (stored_pressure),
        .stored_valve    (stored_valve),
        .stored_time     (stored_time),
        .entry_valid     (entry_valid),
        .last            (last)
    );

endmodule

@@ src/orb_ctrl.sv @@
// Controller state machine: decodes commands and sequences a readout.
`include "overwrite_ring_buffer_readout_top_assert.svh"

module orb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  orb_pkg::dp_status_t status,
    output orb_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import orb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode the word and step the readout
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_PUSH:  cmd.push  = 1'b1;
                        ACT_CLEAR: cmd.clear = 1'b1;
                        ACT_READ:
                        begin
                            if (status.req_zero)
                            begin
                                cmd.emit_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.load_read = 1'b1;
                                state_next    = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                busy          = 1'b1;
                cmd.read_step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ORB_ASSERT_NEXT(a_load_enters_read, cmd.load_read, state_reg == ST_READ,
        "readout load did not enter the read state")
    `ORB_ASSERT_NEXT(a_last_step_idles, cmd.read_step && status.last_step,
        state_reg == ST_IDLE, "final read step did not return to idle")
    `ORB_ASSERT_SAME(a_idle_cmds_need_start,
        cmd.push || cmd.clear || cmd.load_read || cmd.emit_empty,
        start && !busy, "command issued without an accepted word")

endmodule

@@ src/orb_dp.sv @@
// Datapath: entry memory, head and fill count, read pointer and result registers.
`include "overwrite_ring_buffer_readout_top_assert.svh"

module orb_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  orb_pkg::dp_cmd_t            cmd,
    input  logic [orb_pkg::PRES_W-1:0]  pressure,
    input  logic [orb_pkg::VALVE_W-1:0] valve_position,
    input  logic [orb_pkg::TIME_W-1:0]  timestamp,
    input  logic [orb_pkg::REQ_W-1:0]   max_entries,
    output orb_pkg::dp_status_t         status,
    output logic                        strobe,
    output logic [orb_pkg::PRES_W-1:0]  stored_pressure,
    output logic [orb_pkg::VALVE_W-1:0] stored_valve,
    output logic [orb_pkg::TIME_W-1:0]  stored_time,
    output logic                        entry_valid,
    output logic                        last
);
    import orb_pkg::*;

    localparam logic [CNT_W:0] DEPTH_SUM = (CNT_W + 1)'(DEPTH);

    entry_t mem [DEPTH];

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  remain_reg;
    entry_t            rd_data_reg;
    logic              strobe_reg;
    logic              valid_reg;
    logic              last_reg;

    logic [CNT_W:0]    tail_sum;
    logic [ADDR_W-1:0] tail;
    logic              full;
    logic [REQ_W-1:0]  count_ext;
    logic [CNT_W-1:0]  req_len;
    entry_t            wr_entry;

    // Locate the tail; a full buffer writes over the head
    assign full     = (count_reg == DEPTH_CNT);
    assign tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail     = (tail_sum >= DEPTH_SUM) ? ADDR_W'(tail_sum - DEPTH_SUM)
                                              : ADDR_W'(tail_sum);

    // Clip the request to the fill count
    assign count_ext = REQ_W'(count_reg);
    assign req_len   = (max_entries < count_ext) ? CNT_W'(max_entries) : count_reg;

    assign status.req_zero  = (req_len == '0);
    assign status.last_step = (remain_reg == CNT_W'(1));

    assign wr_entry.pressure = pressure;
    assign wr_entry.valve    = valve_position;
    assign wr_entry.stamp    = timestamp;

    // Advance the count on push, or the head when full; drop both on clear
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            if (full)
            begin
                head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + ADDR_W'(1);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Hold buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write the memory and read one entry per step
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail] <= wr_entry;
        end
        if (cmd.read_step)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Walk the read pointer and remaining length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            remain_reg <= '0;
        end
        else if (cmd.load_read)
        begin
            rd_ptr_reg <= head_reg;
            remain_reg <= req_len;
        end
        else if (cmd.read_step)
        begin
            rd_ptr_reg <= (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + ADDR_W'(1);
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    // Mark each result word for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.read_step || cmd.emit_empty;
            valid_reg  <= cmd.read_step;
            last_reg   <= cmd.emit_empty || (cmd.read_step && status.last_step);
        end
    end

    // Zero the payload of an empty result
    assign strobe          = strobe_reg;
    assign entry_valid     = valid_reg;
    assign last            = last_reg;
    assign stored_pressure = valid_reg ? rd_data_reg.pressure : '0;
    assign stored_valve    = valid_reg ? rd_data_reg.valve    : '0;
    assign stored_time     = valid_reg ? rd_data_reg.stamp    : '0;

    `ORB_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= DEPTH_CNT,
        "fill count above buffer depth")
    `ORB_ASSERT_SAME(a_step_has_work, cmd.read_step, remain_reg != '0,
        "read step with nothing left to read")
    `ORB_ASSERT_NEXT(a_final_step_last, cmd.read_step && status.last_step,
        strobe_reg && valid_reg && last_reg, "final entry not marked last")
    `ORB_ASSERT_NEXT(a_empty_result, cmd.emit_empty,
        strobe_reg && !valid_reg && last_reg, "empty readout result malformed")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the overwrite-oldest ring buffer readout block.
module testbench;
    import orb_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 4;

    // One readout word as the block should present it
    typedef struct {
        logic [PRES_W-1:0]  pressure;
        logic [VALVE_W-1:0] valve;
        logic [TIME_W-1:0]  stamp;
        logic               valid;
        logic               last;
    } readout_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] action;
    logic [PRES_W-1:0] pressure;
    logic [VALVE_W-1:0] valve_position;
    logic [TIME_W-1:0] timestamp;
    logic [REQ_W-1:0] max_entries;
    logic strobe;
    logic [PRES_W-1:0] stored_pressure;
    logic [VALVE_W-1:0] stored_valve;
    logic [TIME_W-1:0] stored_time;
    logic entry_valid;
    logic last;

    // Shadow copy of the buffer contents
    entry_t            shadow_store [DEPTH];
    logic [ADDR_W-1:0] shadow_head;
    int                shadow_fill;

    readout_t readout_q[$];
    int       error_count;
    int       words_sent;
    int       readouts_sent;
    int       results_seen;
    int       cycle_count;
    bit       gaps_on;

    overwrite_ring_buffer_readout_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .pressure        (pressure),
        .valve_position  (valve_position),
        .timestamp       (timestamp),
        .max_entries     (max_entries),
        .strobe          (strobe),
        .stored_pressure (stored_pressure),
        .stored_valve    (stored_valve),
        .stored_time     (stored_time),
        .entry_valid     (entry_valid),
        .last            (last)
    );

    // Generate the clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readout words pending",
                     cycle_count, readout_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // Apply one accepted word to the shadow buffer and queue its readout words
    task automatic update_shadow(input logic [1:0] act, input logic [PRES_W-1:0] p,
                                 input logic [VALVE_W-1:0] v, input logic [TIME_W-1:0] t,
                                 input logic [REQ_W-1:0] req);
        logic [ADDR_W-1:0] slot;
        int                n;
        readout_t          word;
        case (act)
            ACT_PUSH:
            begin
                // Drop the oldest entry when full
                if (shadow_fill == DEPTH)
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_fill = DEPTH - 1;
                end
                slot = shadow_head + ADDR_W'(shadow_fill);
                shadow_store[slot] = '{pressure: p, valve: v, stamp: t};
                shadow_fill++;
            end
            ACT_READ:
            begin
                n = (shadow_fill < int'(req)) ? shadow_fill : int'(req);
                if (n == 0)
                begin
                    word = '{pressure: '0, valve: '0, stamp: '0, valid: 1'b0, last: 1'b1};
                    readout_q.push_back(word);
                end
                for (int i = 0; i < n; i++)
                begin
                    slot = shadow_head + ADDR_W'(i);
                    word.pressure = shadow_store[slot].pressure;
                    word.valve    = shadow_store[slot].valve;
                    word.stamp    = shadow_store[slot].stamp;
                    word.valid    = 1'b1;
                    word.last     = (i == n - 1);
                    readout_q.push_back(word);
                end
            end
            ACT_CLEAR:
            begin
                shadow_head = '0;
                shadow_fill = 0;
            end
            default: ;
        endcase
    endtask

    // Present one word and hold it until the block takes it
    task automatic send_word(input logic [1:0] act, input logic [PRES_W-1:0] p,
                             input logic [VALVE_W-1:0] v, input logic [TIME_W-1:0] t,
                             input logic [REQ_W-1:0] req);
        start          <= 1'b1;
        action         <= act;
        pressure       <= p;
        valve_position <= v;
        timestamp      <= t;
        max_entries    <= req;
        do
            @(posedge clk);
        while (busy);
        update_shadow(act, p, v, t, req);
        words_sent++;
        if (act == ACT_READ)
            readouts_sent++;
        // Insert a random idle burst after some words
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    function automatic logic [VALVE_W-1:0] pick_valve();
        if ($urandom_range(0, 3) == 0)
            return VALVE_W'($urandom_range(101, 127));
        return VALVE_W'($urandom_range(0, 100));
    endfunction

    task automatic push_random();
        send_word(ACT_PUSH, PRES_W'($urandom), pick_valve(), $urandom,
                  REQ_W'($urandom_range(0, 127)));
    endtask

    task automatic read_oldest(input int req);
        send_word(ACT_READ, PRES_W'($urandom), VALVE_W'($urandom_range(0, 127)), $urandom,
                  REQ_W'(req));
    endtask

    task automatic send_other(input logic [1:0] act);
        send_word(act, PRES_W'($urandom), VALVE_W'($urandom_range(0, 127)), $urandom,
                  REQ_W'($urandom_range(0, 127)));
    endtask

    // Check each result word in the middle of its strobe cycle
    always @(negedge clk)
    begin
        readout_t want;
        if (rst_n && strobe)
        begin
            if (readout_q.size() == 0)
            begin
                $display("unexpected result word: valid %0b last %0b time 0x%0h",
                         entry_valid, last, stored_time);
                error_count++;
            end
            else
            begin
                want = readout_q.pop_front();
                if (stored_pressure !== want.pressure)
                    report_mismatch("stored_pressure", 64'(stored_pressure), 64'(want.pressure));
                if (stored_valve !== want.valve)
                    report_mismatch("stored_valve", 64'(stored_valve), 64'(want.valve));
                if (stored_time !== want.stamp)
                    report_mismatch("stored_time", 64'(stored_time), 64'(want.stamp));
                if (entry_valid !== want.valid)
                    report_mismatch("entry_valid", 64'(entry_valid), 64'(want.valid));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
            results_seen++;
        end
    end

    // Empty reads, field extremes, exact and oversize requests, clear, unused action
    task automatic test_directed_corners();
        read_oldest(5);
        read_oldest(0);
        send_word(ACT_PUSH, 16'h0000, 7'd0, 32'h0000_0000, 7'd0);
        send_word(ACT_PUSH, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 7'd127);
        send_word(ACT_PUSH, 16'h1280, 7'd100, 32'h5555_AAAA, 7'h55);
        send_word(ACT_PUSH, 16'hAAAA, 7'd101, 32'hAAAA_5555, 7'h2A);
        read_oldest(0);
        read_oldest(1);
        read_oldest(4);
        read_oldest(127);
        read_oldest(64);
        send_other(ACT_UNUSED);
        read_oldest(2);
        send_other(ACT_CLEAR);
        read_oldest(64);
        push_random();
        read_oldest(1);
        send_other(ACT_CLEAR);
        send_other(ACT_UNUSED);
        read_oldest(127);
    endtask

    // Overfill so the head wraps and the oldest entries drop out
    task automatic test_overwrite_wrap();
        send_other(ACT_CLEAR);
        repeat (70) push_random();
        read_oldest(64);
        read_oldest(127);
        repeat (3) push_random();
        read_oldest(10);
    endtask

    // Random push bursts and readouts, with clears and unused actions as noise
    task automatic test_random_mix(input int count);
        int stop_at;
        int pick;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                repeat ($urandom_range(1, 12)) push_random();
            else if (pick < 85)
                read_oldest(($urandom_range(0, 4) == 0) ? $urandom_range(65, 127)
                                                        : $urandom_range(0, 20));
            else if (pick < 93)
                send_other(ACT_CLEAR);
            else
                send_other(ACT_UNUSED);
        end
    endtask

    // Back-to-back words with no idling on the sender side
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (10)
        begin
            push_random();
            read_oldest($urandom_range(0, 3));
            read_oldest($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        action         <= ACT_PUSH;
        pressure       <= '0;
        valve_position <= '0;
        timestamp      <= '0;
        max_entries    <= '0;
        shadow_head     = '0;
        shadow_fill     = 0;
        error_count     = 0;
        words_sent      = 0;
        readouts_sent   = 0;
        results_seen    = 0;
        cycle_count     = 0;
        gaps_on         = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_overwrite_wrap();
        test_random_mix(110);
        test_back_to_back();

        // Drain outstanding readout words
        start <= 1'b0;
        while (readout_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d words including %0d readouts; checked %0d result words",
                 words_sent, readouts_sent, results_seen);
        $display("covered empty and zero requests, full wrap with overwrite, clears, gaps");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
